FILE: hdl/xorshift32_ranged_random_assert.svh
// ============================================================================
// xorshift32_ranged_random_assert.svh
// Assertion macros shared by the ranged random generator RTL.
// ============================================================================
`ifndef XORSHIFT32_RANGED_RANDOM_ASSERT_SVH
`define XORSHIFT32_RANGED_RANDOM_ASSERT_SVH

// Check a condition on the cycle after a trigger.
`define XRR_ASSERT_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("xorshift32_ranged_random: next-cycle check failed");

// Check a condition in the same cycle as a trigger.
`define XRR_ASSERT_SAME(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("xorshift32_ranged_random: same-cycle check failed");

`endif

FILE: hdl/xrr_pkg.sv
// ============================================================================
// xrr_pkg
// Types, constants and the generator step function for the ranged generator.
// ============================================================================
package xrr_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BOUND_W = 31;
   localparam int unsigned COUNT_W = 5;

   localparam logic [WORD_W-1:0]  GEN_SEED   = 32'd123456;
   localparam logic [COUNT_W-1:0] LAST_STEP  = 5'd31;
   localparam int unsigned        SHIFT_A    = 13;
   localparam int unsigned        SHIFT_B    = 17;
   localparam int unsigned        SHIFT_C    = 5;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_HOLD   = 3'b100
   } state_type;

   // Command from the sequencer to the remainder unit
   typedef struct packed {
      logic start;
   } div_cmd_type;

   // Status from the remainder unit to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Advance the xorshift32 state by one step
   function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] t;
      t = s ^ (s << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

endpackage

FILE: hdl/xrr_divider.sv
// ============================================================================
// xrr_divider
// Restoring remainder unit: one quotient bit per cycle, one for each dividend bit.
// ============================================================================
module xrr_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  xrr_pkg::div_cmd_type              cmd,
   input  logic [xrr_pkg::WORD_W-1:0]        dividend,
   input  logic [xrr_pkg::BOUND_W-1:0]       divisor,
   output xrr_pkg::div_stat_type             stat,
   output logic [xrr_pkg::BOUND_W-1:0]       remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [xrr_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [xrr_pkg::WORD_W-1:0]        dvd_ff, dvd_in;
   logic [xrr_pkg::BOUND_W-1:0]       dvs_ff, dvs_in;
   logic [xrr_pkg::BOUND_W-1:0]       rem_ff, rem_in;
   logic [xrr_pkg::WORD_W-1:0]        shifted;
   logic [xrr_pkg::WORD_W:0]          diff;

   // Shift in the next dividend bit and trial-subtract the divisor
   assign shifted = {rem_ff, dvd_ff[xrr_pkg::WORD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      if (cmd.start) begin
         // load operands
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         // keep the difference when it does not borrow
         rem_in   = diff[xrr_pkg::WORD_W] ? shifted[xrr_pkg::BOUND_W-1:0]
                                          : diff[xrr_pkg::BOUND_W-1:0];
         dvd_in   = {dvd_ff[xrr_pkg::WORD_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == xrr_pkg::LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/xorshift32_ranged_random.sv
// ============================================================================
// xorshift32_ranged_random
// xorshift32 generator returning a fraction numerator or a value in 1..n.
// ============================================================================
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_bound
//  rsp     | out       | rsp_valid, rsp_ready, rsp_value, rsp_is_fraction
//
// A bound of zero goes to the result register at its transfer, then to the
// output register; a nonzero bound takes the load edge, 32 restoring remainder
// steps, then the capture of the result and its move to the output register.
// One request is in work at a time; req_ready is low meanwhile and rises the
// cycle after the result leaves the sequencer for the output register.
// The output register lets a new request enter while a result waits on rsp;
// a second waiting result stalls the sequencer in its hold state.
// Synchronous reset loads the seed 123456 and empties the output register.
// ============================================================================
`include "xorshift32_ranged_random_assert.svh"

module xorshift32_ranged_random (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [xrr_pkg::BOUND_W-1:0]       req_bound,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [xrr_pkg::WORD_W-1:0]        rsp_value,
   output logic                              rsp_is_fraction
);

   xrr_pkg::state_type                state_ff, state_in;
   logic [xrr_pkg::WORD_W-1:0]        gen_ff, gen_in;
   logic [xrr_pkg::WORD_W-1:0]        gen_next;
   logic [xrr_pkg::WORD_W-1:0]        res_value_ff, res_value_in;
   logic                              res_frac_ff, res_frac_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [xrr_pkg::WORD_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                              rsp_frac_ff, rsp_frac_in;
   logic                              req_xfer;
   logic                              rsp_load;
   xrr_pkg::div_cmd_type              div_cmd;
   xrr_pkg::div_stat_type             div_stat;
   logic [xrr_pkg::BOUND_W-1:0]       div_rem;

   assign req_ready = (state_ff == xrr_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign gen_next  = xrr_pkg::xorshift_step(gen_ff);
   assign rsp_load  = (state_ff == xrr_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   // Start the remainder unit on a ranged request
   assign div_cmd.start = req_xfer && (req_bound != '0);

   xrr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (gen_next),
      .divisor   (req_bound),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   // Sequence one request at a time
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      res_value_in = res_value_ff;
      res_frac_in  = res_frac_ff;
      case (state_ff)
         xrr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               gen_in = gen_next;
               if (req_bound == '0) begin
                  res_value_in = gen_next;
                  res_frac_in  = 1'b1;
                  state_in     = xrr_pkg::ST_HOLD;
               end else begin
                  state_in = xrr_pkg::ST_DIVIDE;
               end
            end
         end
         xrr_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               res_value_in = {1'b0, div_rem} + 1'b1;
               res_frac_in  = 1'b0;
               state_in     = xrr_pkg::ST_HOLD;
            end
         end
         xrr_pkg::ST_HOLD: begin
            if (rsp_load) begin
               state_in = xrr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xrr_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result until the output register frees
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_frac_in  = rsp_frac_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_frac_in  = res_frac_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrr_pkg::ST_IDLE;
         gen_ff       <= xrr_pkg::GEN_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_frac_ff  <= res_frac_in;
      rsp_value_ff <= rsp_value_in;
      rsp_frac_ff  <= rsp_frac_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_is_fraction = rsp_frac_ff;

   // Ranged request must engage the remainder unit
   `XRR_ASSERT_NEXT(a_div_started, div_cmd.start,
                    div_stat.busy && (state_ff == xrr_pkg::ST_DIVIDE))
   // Remainder unit finishes only while the sequencer waits on it
   `XRR_ASSERT_SAME(a_done_in_divide, div_stat.done, state_ff == xrr_pkg::ST_DIVIDE)
   // A ranged result is never zero
   `XRR_ASSERT_SAME(a_ranged_nonzero, rsp_valid && !rsp_is_fraction, rsp_value != '0)
   // Generator state never collapses to zero
   `XRR_ASSERT_SAME(a_state_nonzero, 1'b1, gen_ff != '0)

endmodule
